FILE: rtl/dcf_pkg.sv
// ============================================================================
// DCF transmit machine package
// Shared types and constants for the DCF CSMA/CA transmit machine.
// ============================================================================
package dcf_pkg;

    localparam int CONTENTION_WINDOW = 16;

    localparam int CH_W    = 16;
    localparam int TIMER_W = 12;
    localparam int BO_W    = 10;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DIFS    = 3'd1,
        PH_BACKOFF = 3'd2,
        PH_HDR     = 3'd3,
        PH_FRAME   = 3'd4,
        PH_SIFS    = 3'd5,
        PH_ACK     = 3'd6
    } t_phase;

    typedef enum logic [ADDR_W-1:0] {
        REG_DIFS_SLOTS  = 3'd0,
        REG_SIFS_SLOTS  = 3'd1,
        REG_ACK_SLOTS   = 3'd2,
        REG_FRAME_SLOTS = 3'd3,
        REG_ACK_CODE    = 3'd4
    } t_reg_addr;

    typedef struct packed {
        logic [7:0]         difs_slots;
        logic [7:0]         sifs_slots;
        logic [7:0]         ack_slots;
        logic [TIMER_W-1:0] frame_slots;
        logic [CH_W-1:0]    ack_code;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic               first;
        logic [TIMER_W-1:0] timer;
        logic               link_busy;
        logic [BO_W-1:0]    backoff;
        logic               frozen;
        logic               ack_seen;
    } t_state;

    typedef struct packed {
        logic               collision;
        logic               ack_received;
        logic [BO_W-1:0]    backoff_left;
        logic               transmitting;
        t_phase             phase;
    } t_result;

endpackage

FILE: rtl/dcf_csma_ca_transmit_fsm.sv
// ============================================================================
// DCF CSMA/CA transmit machine
// One station's DCF transmit sequencer, advanced by one slot tick per beat.
// ============================================================================
// Usage:
// Each input beat is one slot tick and carries the observed channel value
// and a random draw. Each tick yields exactly one output beat with the phase
// after the tick, the transmit flag, the remaining backoff and the ACK and
// collision pulses that mark the close of the ACK window.
// The block has an input register and an output register; the phase update
// sits between them. An accepted beat waits in the input register and is
// then registered into the output register once the output side is free.
// One tick is taken every clock cycle when the output side is
// ready. When the receiver stalls, the output beat holds, the input register
// fills, and the input ready drops until the output drains; no beat is lost.
// Configuration registers are written through a plain write port and are
// meant to change only while no tick is in flight.
// Synchronous active-low reset puts the machine in idle with all counters
// cleared, empties both registers and restores the register defaults.
// ============================================================================
module dcf_csma_ca_transmit_fsm
    import dcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Slot tick input.
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [31:0]       i_s_axis_tdata,  // channel_signal[15:0], random_value[31:16]
    // Result output.
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,  // phase[2:0], transmitting[3],
                                               // backoff_left[13:4], ack_received[14],
                                               // collision[15]
    // Configuration writes.
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    t_cfg            r_cfg;
    t_state          r_state;
    t_state          n_state;
    t_result         n_result;
    t_result         r_result;
    logic            r_in_valid;
    logic [CH_W-1:0] r_channel;
    logic [CH_W-1:0] r_random;
    logic            r_out_valid;
    logic            out_free;
    logic            step_go;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step_go         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.difs_slots  <= 8'd2;
            r_cfg.sifs_slots  <= 8'd1;
            r_cfg.ack_slots   <= 8'd2;
            r_cfg.frame_slots <= TIMER_W'(100);
            r_cfg.ack_code    <= CH_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DIFS_SLOTS:  r_cfg.difs_slots  <= i_cfg_wdata[7:0];
                REG_SIFS_SLOTS:  r_cfg.sifs_slots  <= i_cfg_wdata[7:0];
                REG_ACK_SLOTS:   r_cfg.ack_slots   <= i_cfg_wdata[7:0];
                REG_FRAME_SLOTS: r_cfg.frame_slots <= i_cfg_wdata[TIMER_W-1:0];
                REG_ACK_CODE:    r_cfg.ack_code    <= i_cfg_wdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_channel <= i_s_axis_tdata[15:0];
            r_random  <= i_s_axis_tdata[31:16];
        end
    end

    dcf_step u_step (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_channel_signal (r_channel),
        .i_random_value   (r_random),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    // Machine state advances once per tick that moves to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_result;

endmodule

FILE: rtl/dcf_step.sv
// ============================================================================
// DCF slot step
// Next-state and result logic for one slot tick of the transmit machine.
// ============================================================================
module dcf_step
    import dcf_pkg::*;
(
    input  t_state          i_state,
    input  t_cfg            i_cfg,
    input  logic [CH_W-1:0] i_channel_signal,
    input  logic [CH_W-1:0] i_random_value,
    output t_state          o_state,
    output t_result         o_result
);

    function automatic t_state difs_tick(input t_state st, input logic busy_now,
                                         input logic [7:0] difs);
        t_state r;
        r = st;
        if (r.first) begin
            r.link_busy = 1'b0;
            r.timer     = '0;
            r.first     = 1'b0;
        end
        if (r.timer < {4'b0, difs}) begin
            r.link_busy = r.link_busy | busy_now;
            r.timer     = r.timer + 1'b1;
        end else if (r.link_busy) begin
            r.phase = PH_DIFS;
            r.first = 1'b1;
        end else begin
            r.phase = PH_BACKOFF;
            r.first = 1'b1;
        end
        return r;
    endfunction

    logic   busy_now;
    t_state n;
    t_state from_idle;
    logic   ack_pulse;
    logic   col_pulse;

    assign busy_now = (i_channel_signal != '0);

    always_comb begin
        n         = i_state;
        from_idle = i_state;
        ack_pulse = 1'b0;
        col_pulse = 1'b0;
        unique case (i_state.phase)
            PH_DIFS: begin
                n = difs_tick(i_state, busy_now, i_cfg.difs_slots);
            end
            PH_BACKOFF: begin
                if (i_state.first) begin
                    // A frozen count resumes; otherwise draw a fresh one.
                    if (!i_state.frozen) begin
                        n.backoff = BO_W'(i_random_value % CH_W'(CONTENTION_WINDOW));
                    end
                    n.first = 1'b0;
                end else if (!busy_now) begin
                    if (i_state.backoff != '0) begin
                        n.backoff = i_state.backoff - 1'b1;
                    end
                end else begin
                    n.phase  = PH_DIFS;
                    n.first  = 1'b1;
                    n.frozen = 1'b1;
                end
                if (n.backoff == '0) begin
                    n.phase  = PH_HDR;
                    n.first  = 1'b1;
                    n.frozen = 1'b0;
                end
            end
            PH_HDR: begin
                n.phase = PH_FRAME;
                n.first = 1'b1;
            end
            PH_FRAME: begin
                if (i_state.first) begin
                    n.first = 1'b0;
                    n.timer = '0;
                end else begin
                    n.timer = i_state.timer + 1'b1;
                    if (n.timer >= i_cfg.frame_slots) begin
                        n.phase = PH_SIFS;
                        n.first = 1'b1;
                    end
                end
            end
            PH_SIFS: begin
                if (i_state.first) begin
                    n.first = 1'b0;
                    n.timer = '0;
                end else begin
                    n.timer = i_state.timer + 1'b1;
                    if (n.timer >= {4'b0, i_cfg.sifs_slots}) begin
                        n.phase = PH_ACK;
                        n.first = 1'b1;
                    end
                end
            end
            PH_ACK: begin
                if (i_state.first) begin
                    n.first    = 1'b0;
                    n.timer    = '0;
                    n.ack_seen = 1'b0;
                end else begin
                    n.timer = i_state.timer + 1'b1;
                    if (i_channel_signal == i_cfg.ack_code) begin
                        n.ack_seen = 1'b1;
                    end
                end
                if (n.timer >= {4'b0, i_cfg.ack_slots}) begin
                    ack_pulse = n.ack_seen;
                    col_pulse = !n.ack_seen;
                    n.phase   = PH_DIFS;
                    n.first   = 1'b1;
                end
            end
            default: begin
                // Idle (and the unused code) starts DIFS and senses this slot.
                from_idle.phase = PH_DIFS;
                from_idle.first = 1'b1;
                n = difs_tick(from_idle, busy_now, i_cfg.difs_slots);
            end
        endcase
    end

    assign o_state                = n;
    assign o_result.phase         = n.phase;
    assign o_result.transmitting  = (n.phase == PH_HDR) || (n.phase == PH_FRAME);
    assign o_result.backoff_left  = n.backoff;
    assign o_result.ack_received  = ack_pulse;
    assign o_result.collision     = col_pulse;

endmodule

FILE: tb/tb_dcf_csma_ca_transmit_fsm.sv
// ============================================================================
// DCF CSMA/CA transmit machine testbench
// Sends slot ticks into the block and runs a behavioral model of the station
// machine next to it. The model predicts one result beat per accepted tick,
// and every output beat is checked field by field against those predictions.
// The run covers hand-built sequences, then random traffic under several
// window settings, with random gaps on both sides and a long output stall.
// ============================================================================
module tb_dcf_csma_ca_transmit_fsm;
    import dcf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 4000;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_PRINTED = 60;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [31:0]       i_s_axis_tdata;   // channel_signal[15:0], random_value[31:16]
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [15:0]       o_m_axis_tdata;   // phase[2:0], transmitting[3], backoff_left[13:4],
                                         // ack_received[14], collision[15]
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]  i_cfg_wdata;

    dcf_csma_ca_transmit_fsm u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Predicted copy of the register file.
    logic [7:0]         cfg_difs;
    logic [7:0]         cfg_sifs;
    logic [7:0]         cfg_ack;
    logic [TIMER_W-1:0] cfg_frame;
    logic [CH_W-1:0]    cfg_ack_code;

    // Predicted station state.
    t_phase             st_phase;
    logic               st_first;
    logic [TIMER_W-1:0] st_timer;
    logic               st_link_busy;
    logic [BO_W-1:0]    st_backoff;
    logic               st_frozen;
    logic               st_ack_seen;

    t_result expected_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int err_count;
    int beats_checked;
    int cycle_count;

    t_result got_beat;
    t_result want_beat;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("MISMATCH at beat %0d: %s", beats_checked, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Station model
    // ------------------------------------------------------------------------
    task automatic enter_phase(input t_phase next);
        st_phase = next;
        st_first = 1'b1;
    endtask

    task automatic difs_slot(input logic busy_now);
        if (st_first) begin
            st_link_busy = 1'b0;
            st_timer     = '0;
            st_first     = 1'b0;
        end
        if (st_timer < cfg_difs) begin
            st_link_busy = st_link_busy | busy_now;
            st_timer     = st_timer + 1'b1;
        end else if (st_link_busy) begin
            enter_phase(PH_DIFS);
        end else begin
            enter_phase(PH_BACKOFF);
        end
    endtask

    // Frame and SIFS: the start tick only clears the timer.
    task automatic timed_slot(input logic [TIMER_W-1:0] len, output logic elapsed);
        if (st_first) begin
            st_first = 1'b0;
            st_timer = '0;
            elapsed  = 1'b0;
        end else begin
            st_timer = st_timer + 1'b1;
            elapsed  = (st_timer >= len);
        end
    endtask

    task automatic predict_tick(input logic [CH_W-1:0] ch, input logic [CH_W-1:0] rnd);
        logic    busy_now;
        logic    ack_pulse;
        logic    col_pulse;
        logic    elapsed;
        t_result r;
        busy_now  = (ch != '0);
        ack_pulse = 1'b0;
        col_pulse = 1'b0;
        case (st_phase)
            PH_DIFS: difs_slot(busy_now);
            PH_BACKOFF: begin
                if (st_first) begin
                    if (!st_frozen)
                        st_backoff = BO_W'(rnd % CONTENTION_WINDOW);
                    st_first = 1'b0;
                end else if (!busy_now) begin
                    if (st_backoff != '0)
                        st_backoff = st_backoff - 1'b1;
                end else begin
                    // A busy slot freezes the count and sends us back to DIFS.
                    enter_phase(PH_DIFS);
                    st_frozen = 1'b1;
                end
                if (st_backoff == '0) begin
                    enter_phase(PH_HDR);
                    st_frozen = 1'b0;
                end
            end
            PH_HDR: enter_phase(PH_FRAME);
            PH_FRAME: begin
                timed_slot(cfg_frame, elapsed);
                if (elapsed)
                    enter_phase(PH_SIFS);
            end
            PH_SIFS: begin
                timed_slot(TIMER_W'(cfg_sifs), elapsed);
                if (elapsed)
                    enter_phase(PH_ACK);
            end
            PH_ACK: begin
                if (st_first) begin
                    st_first    = 1'b0;
                    st_timer    = '0;
                    st_ack_seen = 1'b0;
                end else begin
                    st_timer = st_timer + 1'b1;
                    if (ch == cfg_ack_code)
                        st_ack_seen = 1'b1;
                end
                if (st_timer >= cfg_ack) begin
                    ack_pulse = st_ack_seen;
                    col_pulse = !st_ack_seen;
                    enter_phase(PH_DIFS);
                end
            end
            default: begin
                // Leaving idle samples the channel in the same tick.
                enter_phase(PH_DIFS);
                difs_slot(busy_now);
            end
        endcase
        r.phase        = st_phase;
        r.transmitting = (st_phase == PH_HDR) || (st_phase == PH_FRAME);
        r.backoff_left = st_backoff;
        r.ack_received = ack_pulse;
        r.collision    = col_pulse;
        expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_slot_tick(input logic [CH_W-1:0] ch, input logic [CH_W-1:0] rnd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rnd, ch};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predict_tick(ch, rnd);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_beat = t_result'(o_m_axis_tdata);
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat 0x%04h", o_m_axis_tdata));
            end else begin
                want_beat = expected_results.pop_front();
                if (got_beat.phase !== want_beat.phase)
                    report_mismatch($sformatf("phase got %0d want %0d",
                                              got_beat.phase, want_beat.phase));
                if (got_beat.transmitting !== want_beat.transmitting)
                    report_mismatch($sformatf("transmitting got %0b want %0b",
                                              got_beat.transmitting, want_beat.transmitting));
                if (got_beat.backoff_left !== want_beat.backoff_left)
                    report_mismatch($sformatf("backoff_left got %0d want %0d",
                                              got_beat.backoff_left, want_beat.backoff_left));
                if (got_beat.ack_received !== want_beat.ack_received)
                    report_mismatch($sformatf("ack_received got %0b want %0b",
                                              got_beat.ack_received, want_beat.ack_received));
                if (got_beat.collision !== want_beat.collision)
                    report_mismatch($sformatf("collision got %0b want %0b",
                                              got_beat.collision, want_beat.collision));
            end
            beats_checked++;
        end
    end

    // Drains the block so that register writes see no tick in flight.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_addr addr, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        case (addr)
            REG_DIFS_SLOTS:  cfg_difs     = value[7:0];
            REG_SIFS_SLOTS:  cfg_sifs     = value[7:0];
            REG_ACK_SLOTS:   cfg_ack      = value[7:0];
            REG_FRAME_SLOTS: cfg_frame    = value[TIMER_W-1:0];
            REG_ACK_CODE:    cfg_ack_code = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [7:0] difs, input logic [7:0] sifs,
                                input logic [7:0] ack, input logic [TIMER_W-1:0] frame,
                                input logic [CH_W-1:0] code);
        wait_idle();
        write_reg(REG_DIFS_SLOTS, CFG_W'(difs));
        write_reg(REG_SIFS_SLOTS, CFG_W'(sifs));
        write_reg(REG_ACK_SLOTS, CFG_W'(ack));
        write_reg(REG_FRAME_SLOTS, CFG_W'(frame));
        write_reg(REG_ACK_CODE, code);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // The ACK window gets the signature half the time so both pulses show up.
    // A few slots carry an arbitrary value; the rest follow the busy share.
    function automatic logic [CH_W-1:0] pick_channel(input int busy_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (st_phase == PH_ACK && roll < 50)
            return cfg_ack_code;
        if (roll >= 50 && roll < 55)
            return CH_W'($urandom);
        if ($urandom_range(0, 99) < busy_pct)
            return CH_W'($urandom_range(1, 65535));
        return '0;
    endfunction

    task automatic run_random_ticks(input int count, input int busy_pct);
        for (int i = 0; i < count; i++)
            send_slot_tick(pick_channel(busy_pct), CH_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_sequences();
        // Each word is {random_value, channel_signal}.
        logic [31:0] opening [0:14] = '{
            32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'h0000_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0000,
            32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_1234
        };
        logic [31:0] closing [0:17] = '{
            32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0010_0000,
            32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'h0000_0000, 32'h0000_7FFF, 32'h0000_0000
        };
        set_idling(30, 70);
        // Default registers: busy DIFS rerun, then a backoff frozen and resumed.
        for (int i = 0; i < 15; i++)
            send_slot_tick(opening[i][15:0], opening[i][31:16]);
        // Short windows: one acknowledged frame, then a zero backoff and a miss.
        apply_config(8'd1, 8'd1, 8'd2, 12'd1, 16'hFFFF);
        for (int i = 0; i < 18; i++)
            send_slot_tick(closing[i][15:0], closing[i][31:16]);
    endtask

    task automatic test_short_windows();
        // An ack code of zero makes an idle slot count as the acknowledgment.
        apply_config(8'd1, 8'd1, 8'd1, 12'd1, 16'h0000);
        run_random_ticks(300, 20);
    endtask

    task automatic test_typical_windows();
        apply_config(8'd3, 8'd2, 8'd4, 12'd6, CH_W'($urandom_range(1, 65535)));
        run_random_ticks(400, 15);
    endtask

    task automatic test_longest_windows();
        set_idling(70, 30);
        apply_config(8'd255, 8'd255, 8'd255, 12'd4095, 16'hFFFF);
        run_random_ticks(120, 1);
    endtask

    task automatic test_long_gap_and_ack();
        apply_config(8'd1, 8'd255, 8'd255, 12'd2, 16'h8001);
        run_random_ticks(400, 10);
    endtask

    task automatic test_zero_lengths();
        set_idling(0, 0);
        apply_config(8'd0, 8'd0, 8'd0, 12'd0, CH_W'($urandom));
        run_random_ticks(300, 25);
    endtask

    task automatic test_output_backpressure();
        apply_config(8'd2, 8'd1, 8'd2, 12'd3, 16'h0001);
        hold_requests++;
        run_random_ticks(300, 15);
    endtask

    initial begin
        int waited;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        err_count       = 0;
        beats_checked   = 0;
        cycle_count     = 0;

        cfg_difs     = 8'd2;
        cfg_sifs     = 8'd1;
        cfg_ack      = 8'd2;
        cfg_frame    = 12'd100;
        cfg_ack_code = 16'd1;
        st_phase     = PH_IDLE;
        st_first     = 1'b0;
        st_timer     = '0;
        st_link_busy = 1'b0;
        st_backoff   = '0;
        st_frozen    = 1'b0;
        st_ack_seen  = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_sequences();
        test_short_windows();
        test_typical_windows();
        test_longest_windows();
        test_long_gap_and_ack();
        test_zero_lengths();
        test_output_backpressure();

        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
